@@ hw/rtl/ile_pkg.sv @@
package ile_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int KIND_W = 4;
	localparam int CNT_OUT_W = 8;

	typedef enum logic [KIND_W-1:0] {
		K_APPEND    = 4'd0,
		K_PREPEND   = 4'd1,
		K_INSERT    = 4'd2,
		K_POP_LAST  = 4'd3,
		K_POP_FIRST = 4'd4,
		K_REMOVE    = 4'd5,
		K_CLEAR     = 4'd6,
		K_UPDATE    = 4'd7,
		K_READ      = 4'd8,
		K_SEARCH    = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic             wr;
		logic [POS_W-1:0] pos;
	} cell_ctrl_t;

endpackage

@@ hw/rtl/ile_cell.sv @@
module ile_cell #(
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  ile_pkg::cell_ctrl_t             ctrl,
	input  logic signed [ile_pkg::VAL_W-1:0] value,
	input  logic signed [ile_pkg::VAL_W-1:0] left,
	input  logic signed [ile_pkg::VAL_W-1:0] right,
	output logic signed [ile_pkg::VAL_W-1:0] entry
);
	import ile_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic signed [VAL_W-1:0] entry_q;
	logic signed [VAL_W-1:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		if (ctrl.ins) begin
			if (MY_IDX > ctrl.pos) begin
				entry_d = left;
			end else if (MY_IDX == ctrl.pos) begin
				entry_d = value;
			end
		end else if (ctrl.del) begin
			if (MY_IDX >= ctrl.pos) begin
				entry_d = right;
			end
		end else if (ctrl.wr) begin
			if (MY_IDX == ctrl.pos) begin
				entry_d = value;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

@@ hw/rtl/indexed_list_engine_unit.sv @@
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one entry per cell; insert shifts the cells above the position and remove
// shifts the cells at and above it by one place. A request is taken whenever
// start is high, one per clock: busy is never raised. The cells and the count
// update at the edge that takes the request, the next edge registers the probe
// of the updated cells along with done, which is high for exactly one cycle.
// Results leave in request order. The receiver cannot stall the block, so it
// must take every result in the cycle it is shown. Entries past the count are
// never visible, and reset only clears the count and the control state.
module indexed_list_engine_unit #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ile_pkg::KIND_W-1:0]          kind,
	input  logic [ile_pkg::POS_W-1:0]           position,
	input  logic signed [ile_pkg::VAL_W-1:0]    item_value,
	output logic                                done,
	output logic signed [ile_pkg::VAL_W-1:0]    read_value,
	output logic                                found,
	output logic [1:0]                          status,
	output logic [ile_pkg::CNT_OUT_W-1:0]       entry_count,
	output logic signed [ile_pkg::VAL_W-1:0]    first_value,
	output logic signed [ile_pkg::VAL_W-1:0]    last_value
);
	import ile_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic                    acc;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_d;
	logic [POS_W-1:0]        cnt8;
	logic                    full;
	logic                    empty;
	status_t                 st;
	cell_ctrl_t              ctrl;
	logic signed [VAL_W-1:0] cells [CAPACITY];

	logic                    valid_s1;
	logic                    read_s1;
	logic                    search_s1;
	logic [POS_W-1:0]        pos_s1;
	logic signed [VAL_W-1:0] key_s1;
	status_t                 status_s1;

	logic signed [VAL_W-1:0] rd_sel;
	logic signed [VAL_W-1:0] last_sel;
	logic                    hit;

	logic                    done_q;
	logic signed [VAL_W-1:0] read_value_q;
	logic                    found_q;
	status_t                 status_q;
	logic [CW-1:0]           count_out_q;
	logic signed [VAL_W-1:0] first_q;
	logic signed [VAL_W-1:0] last_q;

	assign busy  = 1'b0;
	assign acc   = start && !busy;
	assign cnt8  = CNT_OUT_W'(count_q);
	assign full  = (count_q == CAP_C);
	assign empty = (count_q == '0);

	// operation decode
	always_comb begin
		st       = ST_OK;
		count_d  = count_q;
		ctrl     = '0;
		ctrl.pos = position;
		case (kind_t'(kind))
			K_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ctrl.ins = 1'b1;
					ctrl.pos = cnt8;
					count_d  = count_q + ONE_C;
				end
			end
			K_PREPEND: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ctrl.ins = 1'b1;
					ctrl.pos = '0;
					count_d  = count_q + ONE_C;
				end
			end
			K_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else if (position > cnt8) begin
					st = ST_RANGE;
				end else begin
					ctrl.ins = 1'b1;
					count_d  = count_q + ONE_C;
				end
			end
			K_POP_LAST: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					count_d = count_q - ONE_C;
				end
			end
			K_POP_FIRST: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					ctrl.del = 1'b1;
					ctrl.pos = '0;
					count_d  = count_q - ONE_C;
				end
			end
			K_REMOVE: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (position >= cnt8) begin
					st = ST_RANGE;
				end else begin
					ctrl.del = 1'b1;
					count_d  = count_q - ONE_C;
				end
			end
			K_CLEAR: begin
				count_d = '0;
			end
			K_UPDATE, K_READ: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (position >= cnt8) begin
					st = ST_RANGE;
				end else begin
					ctrl.wr = (kind_t'(kind) == K_UPDATE);
				end
			end
			default: begin
			end
		endcase
		if (!acc) begin
			ctrl.ins = 1'b0;
			ctrl.del = 1'b0;
			ctrl.wr  = 1'b0;
			count_d  = count_q;
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic signed [VAL_W-1:0] left_v;
			logic signed [VAL_W-1:0] right_v;
			if (g == 0) begin : g_lo
				assign left_v = '0;
			end else begin : g_lm
				assign left_v = cells[g-1];
			end
			if (g == CAPACITY - 1) begin : g_hi
				assign right_v = '0;
			end else begin : g_hm
				assign right_v = cells[g+1];
			end
			ile_cell #(.IDX(g)) u_cell (
				.clk   (clk),
				.ctrl  (ctrl),
				.value (item_value),
				.left  (left_v),
				.right (right_v),
				.entry (cells[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			count_q  <= count_d;
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		read_s1   <= (kind_t'(kind) == K_READ) && (st == ST_OK);
		search_s1 <= (kind_t'(kind) == K_SEARCH);
		pos_s1    <= position;
		key_s1    <= item_value;
		status_s1 <= st;
	end

	// probe the updated cells
	always_comb begin
		rd_sel   = '0;
		last_sel = '0;
		hit      = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (POS_W'(i) == pos_s1) begin
				rd_sel = rd_sel | cells[i];
			end
			if ((CW'(i) + ONE_C) == count_q) begin
				last_sel = last_sel | cells[i];
			end
			if ((CW'(i) < count_q) && (cells[i] == key_s1)) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		read_value_q <= read_s1 ? rd_sel : '0;
		found_q      <= search_s1 && hit;
		status_q     <= status_s1;
		count_out_q  <= count_q;
		first_q      <= (count_q == '0) ? '0 : cells[0];
		last_q       <= (count_q == '0) ? '0 : last_sel;
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign found       = found_q;
	assign status      = status_q;
	assign entry_count = CNT_OUT_W'(count_out_q);
	assign first_value = first_q;
	assign last_value  = last_q;

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without request");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("count beyond capacity");
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (entry_count == CNT_OUT_W'(CAPACITY)))
		else $error("full status with spare room");
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (entry_count == '0 && first_value == '0))
		else $error("empty status on non-empty list");
`endif

endmodule

@@ tb/sv/indexed_list_engine_unit_tb.sv @@
module indexed_list_engine_unit_tb;
	import ile_pkg::*;

	localparam int LIST_CAP = CAPACITY_DEF;
	localparam int RANDOM_OPS = 450;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [KIND_W-1:0] KIND_UNUSED_MIN = 4'(K_SEARCH) + 4'd1;

	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
	} list_op_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    found;
		status_t                 status;
		logic [CNT_OUT_W-1:0]    entry_count;
		logic signed [VAL_W-1:0] first_value;
		logic signed [VAL_W-1:0] last_value;
	} list_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [KIND_W-1:0]       kind = '0;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] item_value = '0;
	logic                    busy;
	logic                    done;
	logic signed [VAL_W-1:0] read_value;
	logic                    found;
	logic [1:0]              status;
	logic [CNT_OUT_W-1:0]    entry_count;
	logic signed [VAL_W-1:0] first_value;
	logic signed [VAL_W-1:0] last_value;

	list_op_t     queued_ops[$];
	list_result_t predicted_results[$];

	// shadow copy of the list
	logic signed [VAL_W-1:0] shadow_vals[LIST_CAP];
	int unsigned             shadow_len = 0;

	int errors = 0;
	int ops_taken = 0;
	int results_checked = 0;
	int search_hits = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;

	indexed_list_engine_unit #(
		.CAPACITY(LIST_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.item_value(item_value),
		.done(done),
		.read_value(read_value),
		.found(found),
		.status(status),
		.entry_count(entry_count),
		.first_value(first_value),
		.last_value(last_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic shift_in_entry(input int unsigned idx, input logic signed [VAL_W-1:0] val);
		for (int unsigned i = shadow_len; i > idx; i--)
			shadow_vals[i] = shadow_vals[i-1];
		shadow_vals[idx] = val;
		shadow_len++;
	endtask

	task automatic shift_out_entry(input int unsigned idx);
		for (int unsigned i = idx; i + 1 < shadow_len; i++)
			shadow_vals[i] = shadow_vals[i+1];
		shadow_len--;
	endtask

	task automatic apply_list_op(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val, output list_result_t r);
		r = '0;
		r.status = ST_OK;
		case (op)
		K_APPEND: begin
			if (shadow_len >= LIST_CAP) r.status = ST_FULL;
			else shift_in_entry(shadow_len, val);
		end
		K_PREPEND: begin
			if (shadow_len >= LIST_CAP) r.status = ST_FULL;
			else shift_in_entry(0, val);
		end
		K_INSERT: begin
			if (shadow_len >= LIST_CAP) r.status = ST_FULL;
			else if (pos > shadow_len) r.status = ST_RANGE;
			else shift_in_entry(pos, val);
		end
		K_POP_LAST: begin
			if (shadow_len == 0) r.status = ST_EMPTY;
			else shadow_len--;
		end
		K_POP_FIRST: begin
			if (shadow_len == 0) r.status = ST_EMPTY;
			else shift_out_entry(0);
		end
		K_REMOVE: begin
			if (shadow_len == 0) r.status = ST_EMPTY;
			else if (pos >= shadow_len) r.status = ST_RANGE;
			else shift_out_entry(pos);
		end
		K_CLEAR: begin
			shadow_len = 0;
		end
		K_UPDATE: begin
			if (shadow_len == 0) r.status = ST_EMPTY;
			else if (pos >= shadow_len) r.status = ST_RANGE;
			else shadow_vals[pos] = val;
		end
		K_READ: begin
			if (shadow_len == 0) r.status = ST_EMPTY;
			else if (pos >= shadow_len) r.status = ST_RANGE;
			else r.read_value = shadow_vals[pos];
		end
		K_SEARCH: begin
			for (int unsigned i = 0; i < shadow_len; i++)
				if (shadow_vals[i] == val) r.found = 1'b1;
		end
		default: begin
		end
		endcase
		r.entry_count = CNT_OUT_W'(shadow_len);
		r.first_value = (shadow_len != 0) ? shadow_vals[0] : '0;
		r.last_value = (shadow_len != 0) ? shadow_vals[shadow_len-1] : '0;
	endtask

	task automatic queue_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
			input logic signed [VAL_W-1:0] v);
		list_op_t op;
		op.kind = k;
		op.position = p;
		op.item_value = v;
		queued_ops.push_back(op);
	endtask

	// driver: bursts of requests with random gaps
	always @(posedge clk) begin
		list_op_t     nxt;
		list_result_t res;
		logic         nxt_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			nxt_start = start;
			if (start && !busy) begin
				apply_list_op(kind, position, item_value, res);
				predicted_results.push_back(res);
				ops_taken++;
				nxt_start = 1'b0;
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (queued_ops.size() > 0) begin
					nxt = queued_ops.pop_front();
					kind <= nxt.kind;
					position <= nxt.position;
					item_value <= nxt.item_value;
					nxt_start = 1'b1;
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			start <= nxt_start;
		end
	end

	// monitor: every done pulse is checked against the oldest prediction
	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_res = predicted_results.pop_front();
				results_checked++;
				status_seen[exp_res.status]++;
				if (exp_res.found) search_hits++;
				if (read_value !== exp_res.read_value) begin
					$error("read_value: expected %0d, got %0d", exp_res.read_value, read_value);
					errors++;
				end
				if (found !== exp_res.found) begin
					$error("found: expected %0d, got %0d", exp_res.found, found);
					errors++;
				end
				if (status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, status);
					errors++;
				end
				if (entry_count !== exp_res.entry_count) begin
					$error("entry_count: expected %0d, got %0d", exp_res.entry_count,
						entry_count);
					errors++;
				end
				if (first_value !== exp_res.first_value) begin
					$error("first_value: expected %0d, got %0d", exp_res.first_value,
						first_value);
					errors++;
				end
				if (last_value !== exp_res.last_value) begin
					$error("last_value: expected %0d, got %0d", exp_res.last_value, last_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("indexed_list_engine_unit_tb failed");
				$finish;
			end
		end
	end

	initial begin
		logic [KIND_W-1:0]       k;
		logic [POS_W-1:0]        p;
		logic signed [VAL_W-1:0] v;
		int                      phase;
		int                      pick;

		// empty list cases
		queue_op(K_POP_LAST, 8'd0, 32'sd0);
		queue_op(K_POP_FIRST, 8'd0, 32'sd0);
		queue_op(K_REMOVE, 8'd0, 32'sd0);
		queue_op(K_UPDATE, 8'd0, 32'sd5);
		queue_op(K_READ, 8'd0, 32'sd0);
		queue_op(K_SEARCH, 8'd0, 32'sd0);
		queue_op(K_INSERT, 8'd1, 32'sd9);
		// extremes and index edges
		queue_op(K_APPEND, 8'd0, 32'sh8000_0000);
		queue_op(K_PREPEND, 8'd255, 32'sh7fff_ffff);
		queue_op(K_INSERT, 8'd2, -32'sd1);
		queue_op(K_INSERT, 8'd255, 32'sd7);
		queue_op(K_READ, 8'd255, 32'sd0);
		queue_op(K_READ, 8'd3, 32'sd0);
		queue_op(K_UPDATE, 8'd1, 32'sh5555_aaaa);
		queue_op(K_UPDATE, 8'd3, 32'sd1);
		queue_op(K_READ, 8'd1, 32'sd0);
		queue_op(K_SEARCH, 8'd0, -32'sd1);
		queue_op(K_SEARCH, 8'd0, 32'sd12345);
		queue_op(K_REMOVE, 8'd1, 32'sd0);
		queue_op(K_REMOVE, 8'd2, 32'sd0);
		queue_op(KIND_UNUSED_MIN, 8'd0, 32'sd3);
		queue_op(4'hf, 8'hff, -32'sd1);
		queue_op(K_CLEAR, 8'd0, 32'sd0);
		queue_op(K_READ, 8'd0, 32'sd0);

		// random part: fill-heavy, drain-heavy and mixed stretches
		for (int n = 0; n < RANDOM_OPS; n++) begin
			phase = (n / 40) % 3;
			pick = $urandom_range(0, 99);
			if (phase == 0 && pick < 65) begin
				k = KIND_W'($urandom_range(4'(K_APPEND), 4'(K_INSERT)));
			end else if (phase == 1 && pick < 60) begin
				k = KIND_W'($urandom_range(4'(K_POP_LAST), 4'(K_REMOVE)));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 3) k = K_CLEAR;
				else if (pick < 6) k = KIND_W'($urandom_range(KIND_UNUSED_MIN, 4'hf));
				else begin
					k = KIND_W'($urandom_range(4'(K_APPEND), 4'(K_SEARCH)));
					if (k == K_CLEAR) k = K_READ;
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < 75) p = POS_W'($urandom_range(0, LIST_CAP + 1));
			else if (pick < 85) p = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'hff;
			else p = POS_W'($urandom_range(0, 255));
			// a small pool of values so searches hit
			case ($urandom_range(0, 14))
			0: v = 32'sh8000_0000;
			1: v = 32'sh7fff_ffff;
			2: v = -32'sd1;
			3: v = 32'sd0;
			4: v = 32'sd42;
			5: v = 32'sh5a5a_5a5a;
			default: v = $urandom;
			endcase
			queue_op(k, p, v);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_ops.size() != 0 || start) @(posedge clk);
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests taken, %0d results checked, %0d search hits",
			ops_taken, results_checked, search_hits);
		$display("status counts: ok %0d, empty %0d, full %0d, out of range %0d",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
			status_seen[ST_RANGE]);
		if (errors == 0) begin
			$display("indexed_list_engine_unit_tb passed");
		end else begin
			$display("indexed_list_engine_unit_tb failed");
		end
		$finish;
	end

endmodule
